// ----- rtl/core/amsd_pkg.sv -----
// shared types, constants and the segment decoder for the averaging meter
package amsd_pkg;

  // fixed field widths
  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned SCALE_W    = 6;
  localparam int unsigned PROD_W     = SAMPLE_W + SCALE_W;
  localparam int unsigned READ_W     = PROD_W - 2;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned BCD_DIGITS = 5;
  localparam int unsigned MAX_DIGITS = 4;
  localparam int unsigned POS_W      = 2;
  localparam int unsigned SEG_W      = 7;
  localparam int unsigned SEL_W      = MAX_DIGITS;

  // configuration port
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned IDX_W  = ADDR_W - 2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_SCALE = 1'b0;

  // scale reset value, 2.5 in quarters
  localparam logic [SCALE_W-1:0] SCALE_RESET = 6'd10;

  // request codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // queue depth between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic                cmd;
    logic [SAMPLE_W-1:0] sample;
  } item_t;

  typedef logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits_t;

  typedef struct packed {
    logic busy;
    logic done;
  } conv_stat_t;

  typedef enum logic [1:0] {
    CONV_IDLE,
    CONV_DIV,
    CONV_MUL,
    CONV_BCD
  } conv_state_e;

  // seven-segment pattern, bit0 = a .. bit6 = g; codes above nine show zero
  function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] p;
    case (d)
      4'd0:    p = 7'h3F;
      4'd1:    p = 7'h06;
      4'd2:    p = 7'h5B;
      4'd3:    p = 7'h4F;
      4'd4:    p = 7'h66;
      4'd5:    p = 7'h6D;
      4'd6:    p = 7'h7D;
      4'd7:    p = 7'h07;
      4'd8:    p = 7'h7F;
      4'd9:    p = 7'h6F;
      default: p = 7'h3F;
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/core/amsd_front.sv -----
// front end: accepts requests and holds them in a short queue for the back end
module amsd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                cmd_i,
  input  logic [amsd_pkg::SAMPLE_W-1:0] sample_i,
  output logic                q_valid_o,
  output amsd_pkg::item_t     q_item_o,
  input  logic                q_pop_i
);

  localparam int unsigned PTR_W  = $clog2(amsd_pkg::QUEUE_DEPTH);
  localparam int unsigned FILL_W = $clog2(amsd_pkg::QUEUE_DEPTH + 1);

  amsd_pkg::item_t entries_q [amsd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              push;
  logic              pop;

  // handshake
  assign in_stall_o = (fill_q == FILL_W'(amsd_pkg::QUEUE_DEPTH));
  assign push       = in_valid_i & ~in_stall_o;
  assign q_valid_o  = (fill_q != '0);
  assign pop        = q_pop_i & q_valid_o;
  assign q_item_o   = entries_q[rd_ptr_q];

  // pointer and fill update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(amsd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(amsd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   fill_d = fill_q + 1'b1;
      2'b01:   fill_d = fill_q - 1'b1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= '{cmd: cmd_i, sample: sample_i};
    end
  end

endmodule

// ----- rtl/core/amsd_conv.sv -----
// reading converter: divides the sum, scales it and splits it into decimal digits
module amsd_conv #(
  parameter int unsigned SUM_W               = 18,
  parameter int unsigned SAMPLES_PER_READING = 256,
  parameter int unsigned DIGIT_COUNT         = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [SUM_W-1:0]             sum_i,
  input  logic [amsd_pkg::SCALE_W-1:0] scale_i,
  output amsd_pkg::conv_stat_t         stat_o,
  output amsd_pkg::digits_t            digits_o
);

  // reciprocal of the sample count, exact for every sum that fits SUM_W
  localparam int unsigned     DIV_SHIFT = SUM_W + $clog2(SAMPLES_PER_READING);
  localparam longint unsigned RECIP     =
    ((64'd1 << DIV_SHIFT) + 64'(SAMPLES_PER_READING) - 64'd1) / 64'(SAMPLES_PER_READING);
  localparam int unsigned     RECIP_W   = $clog2(RECIP + 64'd1);
  localparam int unsigned     QPROD_W   = SUM_W + RECIP_W;
  localparam int unsigned     STEP_W    = $clog2(amsd_pkg::READ_W);

  amsd_pkg::conv_state_e state_q, state_d;
  logic [STEP_W-1:0]             step_q, step_d;
  logic [SUM_W-1:0]              work_q, work_d;
  logic [amsd_pkg::READ_W-1:0]   bin_q, bin_d;
  logic [amsd_pkg::BCD_DIGITS-1:0][amsd_pkg::DIGIT_W-1:0] bcd_q, bcd_d;
  logic [amsd_pkg::BCD_DIGITS-1:0][amsd_pkg::DIGIT_W-1:0] bcd_adj;
  logic [amsd_pkg::BCD_DIGITS-1:0][amsd_pkg::DIGIT_W-1:0] bcd_next;
  logic [QPROD_W-1:0]            qprod;
  logic [amsd_pkg::PROD_W-1:0]   prod;
  logic                          bcd_last;

  // average of the set by reciprocal multiply
  assign qprod = QPROD_W'(work_q) * QPROD_W'(RECIP);

  // average times scale, quotient fits the sample width
  assign prod = amsd_pkg::PROD_W'(work_q[amsd_pkg::SAMPLE_W-1:0])
              * amsd_pkg::PROD_W'(scale_i);

  // double-dabble digit correction
  always_comb begin
    for (int i = 0; i < amsd_pkg::BCD_DIGITS; i++) begin
      bcd_adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
    end
  end

  // corrected digits shifted left with the next binary bit
  assign bcd_next = {bcd_adj[amsd_pkg::BCD_DIGITS-1][amsd_pkg::DIGIT_W-2:0],
                     bcd_adj[amsd_pkg::BCD_DIGITS-2:0], bin_q[amsd_pkg::READ_W-1]};

  assign bcd_last = (step_q == STEP_W'(amsd_pkg::READ_W - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      amsd_pkg::CONV_IDLE: if (start_i)  state_d = amsd_pkg::CONV_DIV;
      amsd_pkg::CONV_DIV:  state_d = amsd_pkg::CONV_MUL;
      amsd_pkg::CONV_MUL:  state_d = amsd_pkg::CONV_BCD;
      amsd_pkg::CONV_BCD:  if (bcd_last) state_d = amsd_pkg::CONV_IDLE;
      default:             state_d = amsd_pkg::CONV_IDLE;
    endcase
  end

  // status outputs
  always_comb begin
    stat_o = '{busy: 1'b0, done: 1'b0};
    unique case (state_q)
      amsd_pkg::CONV_IDLE: stat_o = '{busy: 1'b0, done: 1'b0};
      amsd_pkg::CONV_DIV,
      amsd_pkg::CONV_MUL:  stat_o = '{busy: 1'b1, done: 1'b0};
      amsd_pkg::CONV_BCD:  stat_o = '{busy: 1'b1, done: bcd_last};
      default:             stat_o = '{busy: 1'b0, done: 1'b0};
    endcase
  end

  // low digits of the final shift, unused positions read zero
  always_comb begin
    for (int i = 0; i < amsd_pkg::MAX_DIGITS; i++) begin
      if (i < DIGIT_COUNT) begin
        digits_o[i] = bcd_next[i];
      end else begin
        digits_o[i] = '0;
      end
    end
  end

  // datapath
  always_comb begin
    step_d = step_q;
    work_d = work_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    unique case (state_q)
      amsd_pkg::CONV_IDLE: begin
        if (start_i) begin
          work_d = sum_i;
          step_d = '0;
        end
      end
      amsd_pkg::CONV_DIV: begin
        work_d = SUM_W'(qprod >> DIV_SHIFT);
      end
      amsd_pkg::CONV_MUL: begin
        bin_d = prod[amsd_pkg::PROD_W-1:2];
        bcd_d = '0;
      end
      amsd_pkg::CONV_BCD: begin
        bcd_d  = bcd_next;
        bin_d  = {bin_q[amsd_pkg::READ_W-2:0], 1'b0};
        step_d = step_q + 1'b1;
      end
      default: begin
        step_d = step_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= amsd_pkg::CONV_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
  end

endmodule

// ----- rtl/core/amsd_back.sv -----
// back end: sample accumulation, digit store, display scan and result register
module amsd_back #(
  parameter int unsigned SUM_W               = 18,
  parameter int unsigned SAMPLES_PER_READING = 256,
  parameter int unsigned DIGIT_COUNT         = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  amsd_pkg::item_t               q_item_i,
  output logic                          q_pop_o,
  output logic                          conv_start_o,
  output logic [SUM_W-1:0]              conv_sum_o,
  input  amsd_pkg::conv_stat_t          conv_stat_i,
  input  amsd_pkg::digits_t             conv_digits_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [amsd_pkg::SEG_W-1:0]    segments_o,
  output logic [amsd_pkg::SEL_W-1:0]    digit_select_o
);

  localparam int unsigned CNT_W = $clog2(SAMPLES_PER_READING);

  logic [SUM_W-1:0]           sum_q, sum_d;
  logic [CNT_W-1:0]           count_q, count_d;
  amsd_pkg::digits_t          store_q;
  logic [amsd_pkg::POS_W-1:0] pos_q, pos_d;
  logic                       out_valid_q, out_valid_d;
  logic [amsd_pkg::SEG_W-1:0] seg_q;
  logic [amsd_pkg::SEL_W-1:0] sel_q;
  logic                       out_free;
  logic                       take;
  logic                       take_sample;
  logic                       take_tick;
  logic                       last_sample;
  logic [SUM_W-1:0]           sum_total;

  // take a request when the converter is quiet and a tick has room to land
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign take        = q_valid_i & ~conv_stat_i.busy
                     & ((q_item_i.cmd == amsd_pkg::CMD_SAMPLE) | out_free);
  assign take_sample = take & (q_item_i.cmd == amsd_pkg::CMD_SAMPLE);
  assign take_tick   = take & (q_item_i.cmd == amsd_pkg::CMD_TICK);
  assign q_pop_o     = take;

  // accumulation
  assign sum_total    = sum_q + SUM_W'(q_item_i.sample);
  assign last_sample  = (count_q == CNT_W'(SAMPLES_PER_READING - 1));
  assign conv_start_o = take_sample & last_sample;
  assign conv_sum_o   = sum_total;

  always_comb begin
    sum_d   = sum_q;
    count_d = count_q;
    if (take_sample) begin
      sum_d   = last_sample ? '0 : sum_total;
      count_d = last_sample ? '0 : count_q + 1'b1;
    end
  end

  // scan position
  always_comb begin
    pos_d = pos_q;
    if (take_tick) begin
      pos_d = (pos_q == amsd_pkg::POS_W'(DIGIT_COUNT - 1)) ? '0 : pos_q + 1'b1;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (take_tick) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      count_q     <= '0;
      pos_q       <= '0;
      store_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      if (conv_stat_i.done) begin
        store_q <= conv_digits_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_tick) begin
      seg_q <= amsd_pkg::seg_pattern(store_q[pos_q]);
      sel_q <= amsd_pkg::SEL_W'(1) << pos_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign segments_o     = seg_q;
  assign digit_select_o = sel_q;

endmodule

// ----- rtl/core/averaging_meter_seven_segment_driver.sv -----
// Averaging meter with a multiplexed seven-segment display driver. Each request carries cmd:
// a converter sample (cmd 0) is added to a running sum and gives no result; a scan tick
// (cmd 1) gives one result, the segment pattern and one-hot select of the current digit,
// units first. Requests are taken one per cycle while the converter is idle, a scan tick only
// when the result register is free. When the sample that completes a reading arrives, a
// converter divides the sum by SAMPLES_PER_READING with a reciprocal multiply, multiplies
// by scale_quarters and drops two bits, then converts to decimal one bit per cycle; the back
// end holds all requests while it runs, and a two-entry queue at the input takes up to two
// more requests meanwhile. Readings above the display range keep their low DIGIT_COUNT digits.
// scale_quarters sits at byte address 0 of the register port and resets to 10 (2.5).
module averaging_meter_seven_segment_driver #(
  parameter int unsigned SAMPLES_PER_READING = 256,
  parameter int unsigned DIGIT_COUNT         = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          cmd_i,
  input  logic [amsd_pkg::SAMPLE_W-1:0] sample_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [amsd_pkg::SEG_W-1:0]    segments_o,
  output logic [amsd_pkg::SEL_W-1:0]    digit_select_o,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [amsd_pkg::ADDR_W-1:0]   paddr,
  input  logic [amsd_pkg::DATA_W-1:0]   pwdata,
  output logic [amsd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned SUM_W = $clog2(1023 * SAMPLES_PER_READING + 1);

  logic [amsd_pkg::SCALE_W-1:0] scale_q;
  logic                         reg_hit;
  logic                         q_valid;
  amsd_pkg::item_t              q_item;
  logic                         q_pop;
  logic                         conv_start;
  logic [SUM_W-1:0]             conv_sum;
  amsd_pkg::conv_stat_t         conv_stat;
  amsd_pkg::digits_t            conv_digits;

  // register port
  assign pready  = 1'b1;
  assign reg_hit = (paddr[amsd_pkg::ADDR_W-1:2] == amsd_pkg::REG_SCALE);
  assign prdata  = reg_hit ? amsd_pkg::DATA_W'(scale_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= amsd_pkg::SCALE_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      scale_q <= pwdata[amsd_pkg::SCALE_W-1:0];
    end
  end

  // request queue
  amsd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .sample_i   (sample_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  // reading converter
  amsd_conv #(
    .SUM_W               (SUM_W),
    .SAMPLES_PER_READING (SAMPLES_PER_READING),
    .DIGIT_COUNT         (DIGIT_COUNT)
  ) u_conv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (conv_start),
    .sum_i    (conv_sum),
    .scale_i  (scale_q),
    .stat_o   (conv_stat),
    .digits_o (conv_digits)
  );

  // accumulation and display scan
  amsd_back #(
    .SUM_W               (SUM_W),
    .SAMPLES_PER_READING (SAMPLES_PER_READING),
    .DIGIT_COUNT         (DIGIT_COUNT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .q_pop_o        (q_pop),
    .conv_start_o   (conv_start),
    .conv_sum_o     (conv_sum),
    .conv_stat_i    (conv_stat),
    .conv_digits_i  (conv_digits),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .segments_o     (segments_o),
    .digit_select_o (digit_select_o)
  );

endmodule

// ----- bench/averaging_meter_seven_segment_driver_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the averaging meter seven-segment driver
module averaging_meter_seven_segment_driver_tb;

  localparam int unsigned SAMPLES_PER_SET = 256;
  localparam int unsigned SET_SHIFT       = $clog2(SAMPLES_PER_SET);
  localparam int unsigned DISPLAY_MOD     = 10000;
  localparam int unsigned SETTLE_CYCLES   = 64;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned PHASE_COUNT     = 4;
  localparam int unsigned DIRECTED_ROWS   = 16;
  localparam int unsigned SAMPLE_MAX      = (1 << amsd_pkg::SAMPLE_W) - 1;

  localparam logic [amsd_pkg::ADDR_W-1:0] SCALE_ADDR =
    amsd_pkg::ADDR_W'(4 * amsd_pkg::REG_SCALE);
  localparam logic [amsd_pkg::ADDR_W-1:0] SPARE_ADDR = amsd_pkg::ADDR_W'(4);

  // segment pattern per decimal digit, bit0 = a
  localparam logic [amsd_pkg::SEG_W-1:0] SEG_OF_DIGIT [0:9] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  typedef struct packed {
    logic [amsd_pkg::SEG_W-1:0] seg;
    logic [amsd_pkg::SEL_W-1:0] sel;
  } scan_out_t;

  typedef struct packed {
    logic                          cmd;
    logic [amsd_pkg::SAMPLE_W-1:0] sample;
    logic                          known;
    logic [amsd_pkg::SEG_W-1:0]    seg;
    logic [amsd_pkg::SEL_W-1:0]    sel;
  } dir_row_t;

  typedef enum int {
    FILL_FULL,
    FILL_MAX,
    FILL_HIGH
  } fill_e;

  // directed requests; ticks with known patterns carry them, others use the predictor
  localparam dir_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
    '{amsd_pkg::CMD_TICK,   10'd0,    1'b1, 7'h3F, 4'b0001},
    '{amsd_pkg::CMD_TICK,   10'd1023, 1'b1, 7'h3F, 4'b0010},
    '{amsd_pkg::CMD_TICK,   10'd0,    1'b1, 7'h3F, 4'b0100},
    '{amsd_pkg::CMD_TICK,   10'h3FF,  1'b1, 7'h3F, 4'b1000},
    '{amsd_pkg::CMD_TICK,   10'd0,    1'b1, 7'h3F, 4'b0001},
    '{amsd_pkg::CMD_SAMPLE, 10'd0,    1'b0, 7'h00, 4'b0000},
    '{amsd_pkg::CMD_SAMPLE, 10'd1023, 1'b0, 7'h00, 4'b0000},
    '{amsd_pkg::CMD_SAMPLE, 10'h155,  1'b0, 7'h00, 4'b0000},
    '{amsd_pkg::CMD_SAMPLE, 10'h2AA,  1'b0, 7'h00, 4'b0000},
    '{amsd_pkg::CMD_TICK,   10'h155,  1'b0, 7'h00, 4'b0000},
    '{amsd_pkg::CMD_SAMPLE, 10'd1,    1'b0, 7'h00, 4'b0000},
    '{amsd_pkg::CMD_SAMPLE, 10'd512,  1'b0, 7'h00, 4'b0000},
    '{amsd_pkg::CMD_TICK,   10'h2AA,  1'b1, 7'h3F, 4'b0100},
    '{amsd_pkg::CMD_TICK,   10'd0,    1'b0, 7'h00, 4'b0000},
    '{amsd_pkg::CMD_TICK,   10'd0,    1'b1, 7'h3F, 4'b0001},
    '{amsd_pkg::CMD_SAMPLE, 10'd1023, 1'b0, 7'h00, 4'b0000}
  };

  // per phase: scale setting and how samples are drawn
  localparam int PHASE_SCALE [0:PHASE_COUNT-1] = '{10, 63, 0, 39};
  localparam int PHASE_FILL  [0:PHASE_COUNT-1] = '{FILL_FULL, FILL_MAX, FILL_FULL, FILL_HIGH};

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic                          cmd_i;
  logic [amsd_pkg::SAMPLE_W-1:0] sample_i;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [amsd_pkg::SEG_W-1:0]    segments_o;
  logic [amsd_pkg::SEL_W-1:0]    digit_select_o;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [amsd_pkg::ADDR_W-1:0]   paddr;
  logic [amsd_pkg::DATA_W-1:0]   pwdata;
  logic [amsd_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  averaging_meter_seven_segment_driver uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .segments_o     (segments_o),
    .digit_select_o (digit_select_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // meter state as the predictor sees it
  logic [17:0]                  acc_sum;
  logic [7:0]                   acc_count;
  logic [amsd_pkg::DIGIT_W-1:0] shown_digit [0:amsd_pkg::MAX_DIGITS-1];
  logic [amsd_pkg::POS_W-1:0]   scan_pos;
  logic [amsd_pkg::SCALE_W-1:0] scale_q;

  scan_out_t   expected_scan [$];
  scan_out_t   want_scan;
  bit          idle_on = 1'b0;
  int unsigned stall_left = 0;
  int unsigned fail_count = 0;
  int unsigned request_count = 0;
  int unsigned scan_count = 0;
  int unsigned reading_count = 0;
  int unsigned cycle_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // next scan output, or accumulate a sample and form a reading on the last of a set
  task automatic predict_request(input logic cmd, input logic [amsd_pkg::SAMPLE_W-1:0] sample,
                                 output logic has_result, output scan_out_t r);
    logic [amsd_pkg::SAMPLE_W-1:0] avg;
    logic [amsd_pkg::PROD_W-1:0]   prod;
    int unsigned                   reading;
    int                            k;
    has_result = 1'b0;
    r = '0;
    if (cmd == amsd_pkg::CMD_SAMPLE) begin
      acc_sum = acc_sum + sample;
      if (acc_count == 8'(SAMPLES_PER_SET - 1)) begin
        avg = amsd_pkg::SAMPLE_W'(acc_sum >> SET_SHIFT);
        prod = amsd_pkg::PROD_W'(avg) * amsd_pkg::PROD_W'(scale_q);
        reading = int'(prod >> 2) % DISPLAY_MOD;
        for (k = 0; k < amsd_pkg::MAX_DIGITS; k++) begin
          shown_digit[k] = amsd_pkg::DIGIT_W'(reading % 10);
          reading = reading / 10;
        end
        acc_sum = '0;
        acc_count = '0;
        reading_count++;
      end else begin
        acc_count = acc_count + 1'b1;
      end
    end else begin
      has_result = 1'b1;
      r.seg = SEG_OF_DIGIT[shown_digit[scan_pos]];
      r.sel = amsd_pkg::SEL_W'(1) << scan_pos;
      scan_pos = scan_pos + 1'b1;
    end
  endtask

  // present one request and hold it until it is taken; called and returns at a falling edge
  task automatic send_request(input logic cmd, input logic [amsd_pkg::SAMPLE_W-1:0] sample,
                              input logic known, input scan_out_t fixed);
    logic      has_result;
    scan_out_t r;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    predict_request(cmd, sample, has_result, r);
    if (has_result) expected_scan.push_back(known ? fixed : r);
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    sample_i   <= sample;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    request_count++;
  endtask

  task automatic send_tick();
    send_request(amsd_pkg::CMD_TICK, amsd_pkg::SAMPLE_W'($urandom_range(0, SAMPLE_MAX)),
                 1'b0, '0);
  endtask

  // one register access, setup then access cycle
  task automatic reg_access(input logic write, input logic [amsd_pkg::ADDR_W-1:0] addr,
                            input logic [amsd_pkg::DATA_W-1:0] data,
                            output logic [amsd_pkg::DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_reg(input logic [amsd_pkg::ADDR_W-1:0] addr,
                           input logic [amsd_pkg::DATA_W-1:0] data);
    logic [amsd_pkg::DATA_W-1:0] unused;
    reg_access(1'b1, addr, data, unused);
    if (addr == SCALE_ADDR) scale_q = data[amsd_pkg::SCALE_W-1:0];
  endtask

  task automatic check_scale_readback();
    logic [amsd_pkg::DATA_W-1:0] rd;
    reg_access(1'b0, SCALE_ADDR, '0, rd);
    if (rd !== amsd_pkg::DATA_W'(scale_q)) begin
      $display("%0t scale readback: expected %0d, actual %0d", $time, scale_q, rd);
      fail_count++;
    end
  endtask

  // let every expected scan output arrive, then allow a reading in flight to finish
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_scan.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // receiver stall in random bursts
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left  <= $urandom_range(0, 6);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // compare each taken scan output with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_scan.size() == 0) begin
        $display("%0t unexpected scan output: expected none, actual seg %h sel %b",
                 $time, segments_o, digit_select_o);
        fail_count++;
      end else begin
        want_scan = expected_scan.pop_front();
        scan_count++;
        if (segments_o !== want_scan.seg) begin
          $display("%0t segments: expected %h, actual %h", $time, want_scan.seg, segments_o);
          fail_count++;
        end
        if (digit_select_o !== want_scan.sel) begin
          $display("%0t digit_select: expected %b, actual %b",
                   $time, want_scan.sel, digit_select_o);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned                   row;
    int unsigned                   phase;
    int unsigned                   samples_left;
    int unsigned                   phase_items;
    logic [amsd_pkg::SAMPLE_W-1:0] s;

    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    cmd_i      = amsd_pkg::CMD_SAMPLE;
    sample_i   = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;

    acc_sum   = '0;
    acc_count = '0;
    scan_pos  = '0;
    scale_q   = amsd_pkg::SCALE_RESET;
    for (row = 0; row < amsd_pkg::MAX_DIGITS; row++) shown_digit[row] = '0;

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    check_scale_readback();

    // directed table
    idle_on = 1'b1;
    for (row = 0; row < DIRECTED_ROWS; row++) begin
      send_request(DIRECTED[row].cmd, DIRECTED[row].sample, DIRECTED[row].known,
                   '{seg: DIRECTED[row].seg, sel: DIRECTED[row].sel});
    end
    settle();

    // random phases, one full sample set each, aligned to set boundaries
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      idle_on = (phase != PHASE_COUNT - 1);
      if (phase != 0) write_reg(SCALE_ADDR, amsd_pkg::DATA_W'(PHASE_SCALE[phase]));
      // write to the unused index must leave the scale alone
      if (PHASE_SCALE[phase] == 0) write_reg(SPARE_ADDR, amsd_pkg::DATA_W'($urandom));
      check_scale_readback();

      samples_left = SAMPLES_PER_SET - acc_count;
      phase_items  = 0;
      while (samples_left != 0) begin
        if (phase != PHASE_COUNT - 1 && phase_items % 64 == 0)
          idle_on = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 9) == 0) begin
          send_tick();
        end else begin
          case (PHASE_FILL[phase])
            FILL_MAX:  s = amsd_pkg::SAMPLE_W'(SAMPLE_MAX);
            FILL_HIGH: s = amsd_pkg::SAMPLE_W'($urandom_range(768, SAMPLE_MAX));
            default: begin
              if ($urandom_range(0, 7) == 0)
                s = $urandom_range(0, 1) ? amsd_pkg::SAMPLE_W'(SAMPLE_MAX) : '0;
              else
                s = amsd_pkg::SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
            end
          endcase
          send_request(amsd_pkg::CMD_SAMPLE, s, 1'b0, '0);
          samples_left--;
        end
        phase_items++;
      end
      // scan all digits of the fresh reading, twice around
      repeat (2 * amsd_pkg::MAX_DIGITS) send_tick();
      settle();
    end

    $display("covered %0d requests, %0d readings and %0d scan outputs checked",
             request_count, reading_count, scan_count);
    $display("scale settings: reset value, out-of-range 63, zero and 39");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- averaging_meter_seven_segment_driver.f -----
rtl/core/amsd_pkg.sv
rtl/core/amsd_front.sv
rtl/core/amsd_conv.sv
rtl/core/amsd_back.sv
rtl/core/averaging_meter_seven_segment_driver.sv
bench/averaging_meter_seven_segment_driver_tb.sv
